[hdl/tqus_pkg.sv]
// shared types, codes and default sizes for the task queue with undo stack
package tqus_pkg;

  localparam int TQUS_WAIT_DEPTH = 16;
  localparam int TQUS_HIST_DEPTH = 16;
  localparam int CNT_W           = 5;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_RUN    = 2'd1,
    REQ_UNDO   = 2'd2,
    REQ_STATUS = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    RES_OK    = 2'd0,
    RES_EMPTY = 2'd1,
    RES_FULL  = 2'd2
  } res_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_W_RD,
    S_W_EMIT,
    S_H_RD,
    S_H_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] task_id;
    logic [15:0] task_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       result_code;
    logic             entry_valid;
    logic             entry_list;
    logic [15:0]      out_task_id;
    logic [15:0]      out_task_time;
    logic [CNT_W-1:0] waiting_count;
    logic [CNT_W-1:0] history_count;
    logic             last_result;
  } out_item_t;

  // stored task word: time in the upper half, id in the lower half
  typedef struct packed {
    logic [15:0] task_time;
    logic [15:0] task_id;
  } task_t;

  // controller to datapath
  typedef struct packed {
    logic accept;     // latch request, arm the walk pointers
    logic exec_load;  // commit add/run/undo (or empty report) and load result
    logic w_load;     // load current waiting entry as a listed result
    logic h_load;     // load current history entry as a listed result
    logic walk;       // history read address follows the walk pointer
  } tqus_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic w_nonempty;
    logic h_nonempty;
    logic w_last;
    logic h_last;
  } tqus_sts_t;

endpackage

[hdl/task_queue_with_undo_stack_top.sv]
// top level of the task queue with undo stack
// A waiting deque of WAIT_DEPTH tasks and a history stack of HIST_DEPTH tasks,
// each task a 16-bit id and a 16-bit duration. Add appends at the deque tail,
// run moves the deque head onto the history top, undo moves the history top
// back to the deque head, and status lists the deque from head to tail and
// then the history from newest to oldest, marking the final result with
// last_result. A request against an empty source reports empty, one into a
// full destination reports full and moves nothing. Add, run and undo go through the
// accept cycle, during which both stores (one read and one write port each)
// are read at the deque head and the history top, and the EXEC state, which
// commits the write and loads the result register. A status dump gives each
// further entry of the same store a read state before its emit state, since
// each entry needs its own registered store read; the first history entry
// after the deque needs no read state, as the history top read at accept is
// still held. When both stores are empty it answers empty through the EXEC
// state. Stall on the result side holds the current step until the result
// register frees up. No new item is taken until every result of the current
// one has been loaded. The stores need no clearing after reset.
module task_queue_with_undo_stack_top import tqus_pkg::*; #(
  parameter int WAIT_DEPTH = TQUS_WAIT_DEPTH,
  parameter int HIST_DEPTH = TQUS_HIST_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  // request items
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  // result items
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  tqus_cmd_t cmd;
  tqus_sts_t sts;

  // sequencing: accept, single commit, or entry-by-entry status walk
  tqus_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_item.req_type),
    .in_stall    (in_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  // stores, pointers, counts and the result register
  tqus_dp #(
    .WAIT_DEPTH (WAIT_DEPTH),
    .HIST_DEPTH (HIST_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

[hdl/tqus_ctrl.sv]
// sequencing state machine for the task queue with undo stack
module tqus_ctrl import tqus_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic [1:0] in_req_type,
  output logic      in_stall,
  input  tqus_sts_t sts,
  output tqus_cmd_t cmd
);

  state_e state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_STATUS) begin
            if (sts.w_nonempty) begin
              state_nxt = S_W_EMIT;
            end else if (sts.h_nonempty) begin
              state_nxt = S_H_EMIT;
            end else begin
              state_nxt = S_EXEC;
            end
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_W_RD: begin
        state_nxt = S_W_EMIT;
      end
      S_W_EMIT: begin
        if (sts.out_free) begin
          if (!sts.w_last) begin
            state_nxt = S_W_RD;
          end else if (sts.h_nonempty) begin
            state_nxt = S_H_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_H_RD: begin
        state_nxt = S_H_EMIT;
      end
      S_H_EMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.h_last ? S_IDLE : S_H_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall      = (state_r != S_IDLE);
    cmd.accept    = (state_r == S_IDLE) && in_valid;
    cmd.exec_load = (state_r == S_EXEC) && sts.out_free;
    cmd.w_load    = (state_r == S_W_EMIT) && sts.out_free;
    cmd.h_load    = (state_r == S_H_EMIT) && sts.out_free;
    cmd.walk      = (state_r == S_W_RD) || (state_r == S_W_EMIT) ||
                    (state_r == S_H_RD) || (state_r == S_H_EMIT);
  end

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.exec_load, cmd.w_load, cmd.h_load}))
    else $error("more than one datapath load in a cycle");

  a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec_load |=> state_r == S_IDLE)
    else $error("controller did not return to idle after a result");

  a_walk_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_W_RD) |=> (state_r == S_W_EMIT))
    else $error("waiting walk read not followed by emit");

endmodule

[hdl/tqus_dp.sv]
// stores, pointers, result register of the task queue with undo stack
module tqus_dp import tqus_pkg::*; #(
  parameter int WAIT_DEPTH = TQUS_WAIT_DEPTH,
  parameter int HIST_DEPTH = TQUS_HIST_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  tqus_cmd_t cmd,
  output tqus_sts_t sts,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int WAW = $clog2(WAIT_DEPTH);
  localparam int WCW = $clog2(WAIT_DEPTH + 1);
  localparam int HAW = $clog2(HIST_DEPTH);
  localparam int HCW = $clog2(HIST_DEPTH + 1);

  logic [WAW-1:0] head_r, head_nxt;
  logic [WCW-1:0] wfill_r, wfill_nxt;
  logic [HCW-1:0] hfill_r, hfill_nxt;
  logic [WAW-1:0] wwalk_r, wwalk_nxt;
  logic [HAW-1:0] hwalk_r, hwalk_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_item_r, out_item_nxt;
  in_item_t       req_r;

  task_t wmem [WAIT_DEPTH];
  task_t hmem [HIST_DEPTH];
  task_t wrd_r, hrd_r;

  logic           wwe, hwe;
  logic [WAW-1:0] wwa, wra;
  logic [HAW-1:0] hwa, hra;
  task_t          wwd;

  logic [WAW:0]   wsum, tsum;
  logic [WAW-1:0] tail, head_inc, head_dec;
  logic [HCW-1:0] hfill_m1;
  logic           w_full, h_full, w_empty, h_empty;
  task_t          req_task;

  logic [1:0]     ex_code;
  logic           ex_valid, ex_list;
  task_t          ex_task;

  assign req_task = '{task_time: req_r.task_time, task_id: req_r.task_id};
  assign w_full   = (wfill_r == WCW'(WAIT_DEPTH));
  assign h_full   = (hfill_r == HCW'(HIST_DEPTH));
  assign w_empty  = (wfill_r == '0);
  assign h_empty  = (hfill_r == '0);
  assign hfill_m1 = hfill_r - HCW'(1);

  // circular index arithmetic, sums stay below twice the depth
  always_comb begin
    wsum = {1'b0, head_r} + {1'b0, wwalk_r};
    wra  = (wsum >= (WAW+1)'(WAIT_DEPTH)) ? WAW'(wsum - (WAW+1)'(WAIT_DEPTH))
                                         : wsum[WAW-1:0];
    tsum = {1'b0, head_r} + {1'b0, wfill_r[WAW-1:0]};
    tail = (tsum >= (WAW+1)'(WAIT_DEPTH)) ? WAW'(tsum - (WAW+1)'(WAIT_DEPTH))
                                         : tsum[WAW-1:0];
    head_inc = (head_r == WAW'(WAIT_DEPTH - 1)) ? '0 : head_r + WAW'(1);
    head_dec = (head_r == '0) ? WAW'(WAIT_DEPTH - 1) : head_r - WAW'(1);
  end

  assign hra = cmd.walk ? hwalk_r : hfill_m1[HAW-1:0];

  // add / run / undo decision and commit
  always_comb begin
    head_nxt  = head_r;
    wfill_nxt = wfill_r;
    hfill_nxt = hfill_r;
    wwe       = 1'b0;
    wwa       = tail;
    wwd       = req_task;
    hwe       = 1'b0;
    hwa       = hfill_r[HAW-1:0];
    ex_code   = RES_OK;
    ex_valid  = 1'b0;
    ex_list   = 1'b0;
    ex_task   = '0;
    case (req_r.req_type)
      REQ_ADD: begin
        if (w_full) begin
          ex_code = RES_FULL;
        end else begin
          ex_valid = 1'b1;
          ex_task  = req_task;
          if (cmd.exec_load) begin
            wwe       = 1'b1;
            wfill_nxt = wfill_r + WCW'(1);
          end
        end
      end
      REQ_RUN: begin
        if (w_empty) begin
          ex_code = RES_EMPTY;
        end else if (h_full) begin
          ex_code = RES_FULL;
        end else begin
          ex_valid = 1'b1;
          ex_list  = 1'b1;
          ex_task  = wrd_r;
          if (cmd.exec_load) begin
            hwe       = 1'b1;
            head_nxt  = head_inc;
            wfill_nxt = wfill_r - WCW'(1);
            hfill_nxt = hfill_r + HCW'(1);
          end
        end
      end
      REQ_UNDO: begin
        if (h_empty) begin
          ex_code = RES_EMPTY;
        end else if (w_full) begin
          ex_code = RES_FULL;
        end else begin
          ex_valid = 1'b1;
          ex_task  = hrd_r;
          wwa      = head_dec;
          wwd      = hrd_r;
          if (cmd.exec_load) begin
            wwe       = 1'b1;
            head_nxt  = head_dec;
            wfill_nxt = wfill_r + WCW'(1);
            hfill_nxt = hfill_r - HCW'(1);
          end
        end
      end
      default: begin
        // status reaches here only with both stores empty
        ex_code = RES_EMPTY;
      end
    endcase
  end

  assign sts.out_free   = !out_valid_r || !out_stall;
  assign sts.w_nonempty = !w_empty;
  assign sts.h_nonempty = !h_empty;
  assign sts.w_last     = (WCW'(wwalk_r) + WCW'(1) == wfill_r);
  assign sts.h_last     = (hwalk_r == '0);

  // walk pointers and result register
  always_comb begin
    wwalk_nxt = wwalk_r;
    hwalk_nxt = hwalk_r;
    if (cmd.accept) begin
      wwalk_nxt = '0;
      hwalk_nxt = hfill_m1[HAW-1:0];
    end else if (cmd.w_load) begin
      wwalk_nxt = sts.w_last ? '0 : wwalk_r + WAW'(1);
    end else if (cmd.h_load && !sts.h_last) begin
      hwalk_nxt = hwalk_r - HAW'(1);
    end

    out_item_nxt               = out_item_r;
    out_item_nxt.waiting_count = CNT_W'(wfill_nxt);
    out_item_nxt.history_count = CNT_W'(hfill_nxt);
    if (cmd.exec_load) begin
      out_item_nxt.result_code   = ex_code;
      out_item_nxt.entry_valid   = ex_valid;
      out_item_nxt.entry_list    = ex_list;
      out_item_nxt.out_task_id   = ex_task.task_id;
      out_item_nxt.out_task_time = ex_task.task_time;
      out_item_nxt.last_result   = 1'b1;
    end else if (cmd.w_load) begin
      out_item_nxt.result_code   = RES_OK;
      out_item_nxt.entry_valid   = 1'b1;
      out_item_nxt.entry_list    = 1'b0;
      out_item_nxt.out_task_id   = wrd_r.task_id;
      out_item_nxt.out_task_time = wrd_r.task_time;
      out_item_nxt.last_result   = sts.w_last && h_empty;
    end else if (cmd.h_load) begin
      out_item_nxt.result_code   = RES_OK;
      out_item_nxt.entry_valid   = 1'b1;
      out_item_nxt.entry_list    = 1'b1;
      out_item_nxt.out_task_id   = hrd_r.task_id;
      out_item_nxt.out_task_time = hrd_r.task_time;
      out_item_nxt.last_result   = sts.h_last;
    end else begin
      out_item_nxt = out_item_r;
    end

    if (cmd.exec_load || cmd.w_load || cmd.h_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      wfill_r     <= '0;
      hfill_r     <= '0;
      wwalk_r     <= '0;
      hwalk_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      wfill_r     <= wfill_nxt;
      hfill_r     <= hfill_nxt;
      wwalk_r     <= wwalk_nxt;
      hwalk_r     <= hwalk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (cmd.accept) begin
      req_r <= in_item;
    end
  end

  // waiting deque memory
  always_ff @(posedge clk) begin
    if (wwe) begin
      wmem[wwa] <= wwd;
    end
    wrd_r <= wmem[wra];
  end

  // history stack memory
  always_ff @(posedge clk) begin
    if (hwe) begin
      hmem[hwa] <= wrd_r;
    end
    hrd_r <= hmem[hra];
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_wfill_max: assert property (@(posedge clk) disable iff (!rst_n)
    wfill_r <= WCW'(WAIT_DEPTH))
    else $error("waiting fill beyond depth");

  a_hfill_max: assert property (@(posedge clk) disable iff (!rst_n)
    hfill_r <= HCW'(HIST_DEPTH))
    else $error("history fill beyond depth");

  a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec_load && ex_code != RES_OK) |=>
      ($stable(wfill_r) && $stable(hfill_r) && $stable(head_r)))
    else $error("refused request changed the stores");

  a_move_conserves: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec_load && (req_r.req_type == REQ_RUN || req_r.req_type == REQ_UNDO)) |=>
      (int'(wfill_r) + int'(hfill_r) == $past(int'(wfill_r) + int'(hfill_r))))
    else $error("run or undo changed the total task count");

endmodule
